### rtl/core/keyed_ordered_list_engine_assert.svh
// Assertion macros for the keyed ordered list engine.
// Depends on clk and rst_n being visible in the module that expands them.
`ifndef KEYED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define KEYED_ORDERED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define KOLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define KOLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/kole_pkg.sv
// Shared types and constants for the keyed ordered list engine.
// No dependencies.
package kole_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_IW   = $clog2(CAPACITY + 1);

  localparam int OP_W  = 4;
  localparam int ID_W  = 31;
  localparam int CNT_W = 11;
  localparam int ST_W  = 3;

  localparam logic [OP_W-1:0] OP_PUT_FRONT  = 4'd0;
  localparam logic [OP_W-1:0] OP_PUT_BACK   = 4'd1;
  localparam logic [OP_W-1:0] OP_INS_BEFORE = 4'd2;
  localparam logic [OP_W-1:0] OP_INS_AFTER  = 4'd3;
  localparam logic [OP_W-1:0] OP_TAKE_FRONT = 4'd4;
  localparam logic [OP_W-1:0] OP_TAKE_BACK  = 4'd5;
  localparam logic [OP_W-1:0] OP_ERASE      = 4'd6;
  localparam logic [OP_W-1:0] OP_BEFORE     = 4'd7;
  localparam logic [OP_W-1:0] OP_AFTER      = 4'd8;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_NOREF   = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_NONEIGH = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic [ID_W-1:0] entry_id;
    logic [ID_W-1:0] reference_id;
  } kole_in_t;

  typedef struct packed {
    logic [ID_W-1:0]  front_id;
    logic [ID_W-1:0]  back_id;
    logic [ID_W-1:0]  neighbor_id;
    logic [CNT_W-1:0] entry_count;
    logic [ST_W-1:0]  status;
  } kole_out_t;

endpackage

### rtl/core/keyed_ordered_list_engine.sv
// Keyed ordered list engine: bounded ordered list of IDs in one RAM, one sequencer.
// Depends on kole_pkg, kole_ram and keyed_ordered_list_engine_assert.svh.
//
//  channel | ports                      | handshake
//  --------+----------------------------+-------------------------------------
//  input   | start, busy, in_item       | item taken when start && !busy
//  result  | out_valid, out_item        | one-cycle strobe, no backpressure
//
// An item's run time is at most linear in the held count (a full list holds
//   1024 entries) and is set by the single RAM read port: the key scan reads
//   one entry a cycle and the shift that follows moves one entry a cycle, both
//   pipelined behind the registered read. A peek or a failed full or empty
//   check skips the scan and the shift.
// busy stays high from the accept edge until the result strobe.
// Reset clears the count and the control state only; the store needs no clearing
//   because any entry read at or above the count is discarded.
// The receiver cannot stall: out_item is valid only in the out_valid cycle.
`include "keyed_ordered_list_engine_assert.svh"

module keyed_ordered_list_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  kole_pkg::kole_in_t in_item,
  output logic               out_valid,
  output kole_pkg::kole_out_t out_item
);
  import kole_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;  // find first entry equal to key
  localparam logic [2:0] S_SHUP = 3'd2;  // open a slot, top down
  localparam logic [2:0] S_SHDN = 3'd3;  // close a slot, bottom up
  localparam logic [2:0] S_NCAP = 3'd4;  // capture neighbor read
  localparam logic [2:0] S_RD0  = 3'd5;  // read front
  localparam logic [2:0] S_RD1  = 3'd6;  // capture front, read back
  localparam logic [2:0] S_RD2  = 3'd7;  // capture back, emit result

  logic [2:0]        state_r, state_nxt;
  logic [CNT_IW-1:0] count_r, count_nxt;
  logic              cmp_v_r, cmp_v_nxt;    // scan read in flight
  logic              pw_v_r, pw_v_nxt;      // shift write pending
  logic              out_valid_r, out_valid_nxt;

  logic [OP_W-1:0]   op_r, op_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [ID_W-1:0]   key_r, key_nxt;
  logic [CNT_IW-1:0] sc_a_r, sc_a_nxt;
  logic [ADDR_W-1:0] cmp_i_r, cmp_i_nxt;
  logic [CNT_IW-1:0] rem_r, rem_nxt;
  logic [ADDR_W-1:0] sh_a_r, sh_a_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [ADDR_W-1:0] pw_a_r, pw_a_nxt;
  logic [ST_W-1:0]   status_r, status_nxt;
  logic [ID_W-1:0]   neigh_r, neigh_nxt;
  logic [ID_W-1:0]   front_r, front_nxt;
  kole_out_t         out_item_r, out_item_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_wa;
  logic [ID_W-1:0]   ram_wd;
  logic [ADDR_W-1:0] ram_ra;
  logic [ID_W-1:0]   ram_rd;

  logic              full;
  logic              empty;
  logic              hit;
  logic [CNT_IW-1:0] hit_pos;

  kole_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ID_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  assign full    = (count_r >= CNT_IW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign hit     = cmp_v_r && (ram_rd == key_r);
  assign hit_pos = CNT_IW'(cmp_i_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cmp_v_nxt     = 1'b0;
    pw_v_nxt      = 1'b0;
    out_valid_nxt = 1'b0;
    op_nxt        = op_r;
    id_nxt        = id_r;
    key_nxt       = key_r;
    sc_a_nxt      = sc_a_r;
    cmp_i_nxt     = cmp_i_r;
    rem_nxt       = rem_r;
    sh_a_nxt      = sh_a_r;
    pos_nxt       = pos_r;
    pw_a_nxt      = pw_a_r;
    status_nxt    = status_r;
    neigh_nxt     = neigh_r;
    front_nxt     = front_r;
    out_item_nxt  = out_item_r;
    // pending shift write lands the data from the shift's registered read
    ram_we        = pw_v_r;
    ram_wa        = pw_a_r;
    ram_wd        = ram_rd;
    ram_ra        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_item.opcode;
          id_nxt     = in_item.entry_id;
          key_nxt    = in_item.reference_id;
          status_nxt = ST_OK;
          neigh_nxt  = '0;
          sc_a_nxt   = '0;
          state_nxt  = S_RD0;
          case (in_item.opcode)
            OP_PUT_FRONT, OP_PUT_BACK: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                pos_nxt   = (in_item.opcode == OP_PUT_FRONT) ? '0 : ADDR_W'(count_r);
                rem_nxt   = (in_item.opcode == OP_PUT_FRONT) ? count_r : '0;
                sh_a_nxt  = ADDR_W'(count_r - 1'b1);
                state_nxt = S_SHUP;
              end
            end
            OP_INS_BEFORE, OP_INS_AFTER: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_TAKE_FRONT: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                rem_nxt   = count_r - 1'b1;
                sh_a_nxt  = ADDR_W'(1);
                state_nxt = S_SHDN;
              end
            end
            OP_TAKE_BACK: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            OP_ERASE: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                key_nxt   = in_item.entry_id;
                state_nxt = S_SCAN;
              end
            end
            OP_BEFORE, OP_AFTER: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              // peek and unused codes: report only
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          state_nxt = S_RD0;
          case (op_r)
            OP_INS_BEFORE: begin
              pos_nxt   = cmp_i_r;
              rem_nxt   = count_r - hit_pos;
              sh_a_nxt  = ADDR_W'(count_r - 1'b1);
              state_nxt = S_SHUP;
            end
            OP_INS_AFTER: begin
              pos_nxt   = cmp_i_r + 1'b1;
              rem_nxt   = count_r - hit_pos - 1'b1;
              sh_a_nxt  = ADDR_W'(count_r - 1'b1);
              state_nxt = S_SHUP;
            end
            OP_ERASE: begin
              rem_nxt   = count_r - hit_pos - 1'b1;
              sh_a_nxt  = cmp_i_r + 1'b1;
              state_nxt = S_SHDN;
            end
            OP_BEFORE: begin
              if (cmp_i_r == '0) begin
                status_nxt = ST_NONEIGH;
              end else begin
                ram_ra    = cmp_i_r - 1'b1;
                state_nxt = S_NCAP;
              end
            end
            OP_AFTER: begin
              if (hit_pos + 1'b1 >= count_r) begin
                status_nxt = ST_NONEIGH;
              end else begin
                ram_ra    = cmp_i_r + 1'b1;
                state_nxt = S_NCAP;
              end
            end
            default: begin
            end
          endcase
        end else if (!cmp_v_r && (sc_a_r >= count_r)) begin
          status_nxt = ST_NOREF;
          state_nxt  = S_RD0;
        end else if (sc_a_r < count_r) begin
          ram_ra    = ADDR_W'(sc_a_r);
          cmp_v_nxt = 1'b1;
          cmp_i_nxt = ADDR_W'(sc_a_r);
          sc_a_nxt  = sc_a_r + 1'b1;
        end
      end

      S_SHUP: begin
        if (rem_r != '0) begin
          ram_ra   = sh_a_r;
          pw_v_nxt = 1'b1;
          pw_a_nxt = sh_a_r + 1'b1;
          sh_a_nxt = sh_a_r - 1'b1;
          rem_nxt  = rem_r - 1'b1;
        end else if (!pw_v_r) begin
          ram_we    = 1'b1;
          ram_wa    = pos_r;
          ram_wd    = id_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_RD0;
        end
      end

      S_SHDN: begin
        if (rem_r != '0) begin
          ram_ra   = sh_a_r;
          pw_v_nxt = 1'b1;
          pw_a_nxt = sh_a_r - 1'b1;
          sh_a_nxt = sh_a_r + 1'b1;
          rem_nxt  = rem_r - 1'b1;
        end else if (!pw_v_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_RD0;
        end
      end

      S_NCAP: begin
        neigh_nxt = ram_rd;
        state_nxt = S_RD0;
      end

      S_RD0: begin
        ram_ra    = '0;
        state_nxt = S_RD1;
      end

      S_RD1: begin
        front_nxt = empty ? '0 : ram_rd;
        ram_ra    = ADDR_W'(count_r - 1'b1);
        state_nxt = S_RD2;
      end

      S_RD2: begin
        out_item_nxt.front_id    = front_r;
        out_item_nxt.back_id     = empty ? '0 : ram_rd;
        out_item_nxt.neighbor_id = neigh_r;
        out_item_nxt.entry_count = CNT_W'(count_r);
        out_item_nxt.status      = status_r;
        out_valid_nxt            = 1'b1;
        state_nxt                = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      pw_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_v_r     <= cmp_v_nxt;
      pw_v_r      <= pw_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and datapath
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    key_r      <= key_nxt;
    sc_a_r     <= sc_a_nxt;
    cmp_i_r    <= cmp_i_nxt;
    rem_r      <= rem_nxt;
    sh_a_r     <= sh_a_nxt;
    pos_r      <= pos_nxt;
    pw_a_r     <= pw_a_nxt;
    status_r   <= status_nxt;
    neigh_r    <= neigh_nxt;
    front_r    <= front_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `KOLE_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_IW'(CAPACITY), "count above capacity")
  `KOLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `KOLE_ASSERT_NOW(a_result_idle, out_valid_r, state_r == S_IDLE, "result strobe while busy")
  `KOLE_ASSERT_NOW(a_empty_count, out_valid_r && (out_item_r.status == ST_EMPTY), out_item_r.entry_count == '0, "empty status with entries held")
  `KOLE_ASSERT_NOW(a_no_stray_write, (state_r == S_IDLE) || (state_r == S_SCAN), !pw_v_r, "shift write pending outside a shift")

endmodule

### rtl/core/kole_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module kole_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 31
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### tb/tb.sv
// Self-checking testbench for keyed_ordered_list_engine: directed corner items,
// then random item streams. Depends on kole_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kole_pkg::*;

  // Opcode 9 is peek; every code above it behaves the same way.
  localparam logic [OP_W-1:0] OP_PEEK = 4'd9;
  localparam logic [OP_W-1:0] OP_LAST = 4'd15;

  localparam logic [ID_W-1:0] ID_MAX  = 31'h7FFF_FFFF;
  localparam logic [ID_W-1:0] ID_ODD  = 31'h2AAA_AAAA;
  localparam logic [ID_W-1:0] ID_EVEN = 31'h5555_5555;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the list, predicted responses waiting in order.
  // --------------------------------------------------------------------------
  class list_scoreboard;
    logic [ID_W-1:0] ids[$];
    kole_out_t       waiting_q[$];
    int              fails = 0;

    // index of the front-most entry equal to key, -1 when absent
    function int find_first(logic [ID_W-1:0] key);
      foreach (ids[i])
        if (ids[i] == key) return i;
      return -1;
    endfunction

    // an index equal to the size appends
    function void place(int slot, logic [ID_W-1:0] id);
      ids.insert(slot, id);
    endfunction

    // apply one accepted item to the shadow list and queue its response
    function void note_item(kole_in_t item);
      kole_out_t resp;
      int        pos;
      resp = '0;
      resp.status = ST_OK;
      case (item.opcode)
        OP_PUT_FRONT, OP_PUT_BACK: begin
          if (ids.size() >= CAPACITY) resp.status = ST_FULL;
          else if (item.opcode == OP_PUT_FRONT) place(0, item.entry_id);
          else place(ids.size(), item.entry_id);
        end
        OP_INS_BEFORE, OP_INS_AFTER: begin
          // full check comes ahead of the reference search
          if (ids.size() >= CAPACITY) begin
            resp.status = ST_FULL;
          end else begin
            pos = find_first(item.reference_id);
            if (pos < 0) resp.status = ST_NOREF;
            else place((item.opcode == OP_INS_BEFORE) ? pos : pos + 1, item.entry_id);
          end
        end
        OP_TAKE_FRONT, OP_TAKE_BACK: begin
          if (ids.size() == 0) resp.status = ST_EMPTY;
          else if (item.opcode == OP_TAKE_FRONT) ids.delete(0);
          else ids.delete(ids.size() - 1);
        end
        OP_ERASE: begin
          if (ids.size() == 0) begin
            resp.status = ST_EMPTY;
          end else begin
            pos = find_first(item.entry_id);
            if (pos < 0) resp.status = ST_NOREF;
            else ids.delete(pos);
          end
        end
        OP_BEFORE, OP_AFTER: begin
          if (ids.size() == 0) begin
            resp.status = ST_EMPTY;
          end else begin
            pos = find_first(item.reference_id);
            if (pos < 0) resp.status = ST_NOREF;
            else if (item.opcode == OP_BEFORE && pos == 0) resp.status = ST_NONEIGH;
            else if (item.opcode == OP_AFTER && pos == ids.size() - 1)
              resp.status = ST_NONEIGH;
            else resp.neighbor_id = ids[(item.opcode == OP_BEFORE) ? pos - 1 : pos + 1];
          end
        end
        default: ;
      endcase
      if (ids.size() != 0) begin
        resp.front_id = ids[0];
        resp.back_id  = ids[ids.size() - 1];
      end
      resp.entry_count = CNT_W'(ids.size());
      waiting_q.insert(waiting_q.size(), resp);
    endfunction

    function void check_result(kole_out_t got);
      kole_out_t want;
      if (waiting_q.size() == 0) begin
        $error("response with no item outstanding: front_id %0h count %0d",
               got.front_id, got.entry_count);
        fails++;
        return;
      end
      want = waiting_q[0];
      waiting_q.delete(0);
      if (got.front_id !== want.front_id) begin
        $error("front_id: expected %0h, got %0h", want.front_id, got.front_id);
        fails++;
      end
      if (got.back_id !== want.back_id) begin
        $error("back_id: expected %0h, got %0h", want.back_id, got.back_id);
        fails++;
      end
      if (got.neighbor_id !== want.neighbor_id) begin
        $error("neighbor_id: expected %0h, got %0h", want.neighbor_id, got.neighbor_id);
        fails++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        fails++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fails++;
      end
    endfunction

    function int outstanding();
      return waiting_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  kole_in_t  in_item = '0;
  logic      out_valid;
  kole_out_t out_item;

  list_scoreboard list_sb = new;

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  keyed_ordered_list_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Responses are one-cycle strobes with no backpressure; sample at every edge.
  always @(posedge clk) begin
    if (rst_n && out_valid) list_sb.check_result(out_item);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic kole_in_t make_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                         logic [ID_W-1:0] ref_id);
    kole_in_t item;
    item.opcode       = op;
    item.entry_id     = id;
    item.reference_id = ref_id;
    return item;
  endfunction

  function automatic logic [ID_W-1:0] random_id();
    return ID_W'($urandom);
  endfunction

  // Picks an ID already held with chance hit_pct in a hundred, so relative ops and erases
  // hit real entries (duplicates included); the rest is noise that usually misses.
  function automatic logic [ID_W-1:0] held_or_random_id(int hit_pct);
    int held;
    held = list_sb.ids.size();
    if (held > 0 && $urandom_range(0, 99) < hit_pct)
      return list_sb.ids[$urandom_range(0, held - 1)];
    return random_id();
  endfunction

  // Op mix is steered by the current size so the list hovers near 0..20
  // entries: small enough to stay fast, large enough for real scans and
  // regular trips back to empty.
  function automatic kole_in_t random_item();
    kole_in_t item;
    int       held;
    int       roll;
    int       grow;
    held = list_sb.ids.size();
    grow = (held < 6) ? 55 : ((held > 20) ? 15 : 35);
    roll = $urandom_range(0, 99);
    item.reference_id = held_or_random_id(85);
    item.entry_id     = held_or_random_id(15);
    if (roll < grow) begin
      case ($urandom_range(0, 3))
        0:       item.opcode = OP_PUT_FRONT;
        1:       item.opcode = OP_PUT_BACK;
        2:       item.opcode = OP_INS_BEFORE;
        default: item.opcode = OP_INS_AFTER;
      endcase
    end else if (roll < grow + 30) begin
      case ($urandom_range(0, 2))
        0:       item.opcode = OP_TAKE_FRONT;
        1:       item.opcode = OP_TAKE_BACK;
        default: begin
          item.opcode   = OP_ERASE;
          item.entry_id = held_or_random_id(80);
        end
      endcase
    end else if (roll < 96) begin
      item.opcode = ($urandom_range(0, 1) != 0) ? OP_BEFORE : OP_AFTER;
    end else begin
      item.opcode = OP_W'($urandom_range(OP_PEEK, OP_LAST));
    end
    return item;
  endfunction

  // Present one item and hold it until the engine takes it. In each cycle
  // the sender idles (start low) with chance idle_pct in a hundred; start is
  // only ever assigned once per edge.
  task automatic send_item(input kole_in_t item, input int idle_pct);
    logic taken;
    in_item <= item;
    start   <= ($urandom_range(0, 99) >= idle_pct);
    do begin
      @(posedge clk);
      taken = start && !busy;
      if (!taken) start <= ($urandom_range(0, 99) >= idle_pct);
    end while (!taken);
    list_sb.note_item(item);
  endtask

  task automatic run_random(input int count, input int idle_pct);
    for (int k = 0; k < count; k++)
      send_item(random_item(), idle_pct);
  endtask

  // Corner items from an empty list: the empty, no-reference and no-neighbor statuses,
  // bit extremes, duplicate IDs, neighbor queries at both ends, high peek codes.
  task automatic run_directed();
    send_item(make_item(OP_TAKE_FRONT, '0,      '0),      0);
    send_item(make_item(OP_TAKE_BACK,  '0,      '0),      0);
    send_item(make_item(OP_ERASE,      ID_MAX,  '0),      0);
    send_item(make_item(OP_BEFORE,     '0,      ID_MAX),  0);
    send_item(make_item(OP_AFTER,      '0,      '0),      0);
    send_item(make_item(OP_INS_BEFORE, ID_MAX,  '0),      0);  // empty: no reference
    send_item(make_item(OP_PEEK,       ID_MAX,  ID_MAX),  0);
    send_item(make_item(OP_PUT_BACK,   ID_MAX,  ID_ODD),  0);
    send_item(make_item(OP_PUT_FRONT,  '0,      ID_EVEN), 0);  // ID zero is legal
    send_item(make_item(OP_PUT_BACK,   ID_ODD,  '0),      0);
    send_item(make_item(OP_INS_AFTER,  ID_EVEN, ID_MAX),  0);
    send_item(make_item(OP_INS_BEFORE, 31'h1234_5678, '0), 0);  // new front
    send_item(make_item(OP_INS_AFTER,  31'h1,   31'h6),   0);  // reference absent
    send_item(make_item(OP_PUT_BACK,   ID_MAX,  '0),      0);  // duplicate at back
    send_item(make_item(OP_BEFORE,     '0,      31'h1234_5678), 0);  // first entry
    send_item(make_item(OP_AFTER,      '0,      ID_MAX),  0);  // first match only
    send_item(make_item(OP_BEFORE,     '0,      ID_MAX),  0);
    send_item(make_item(OP_ERASE,      ID_MAX,  '0),      0);  // front-most copy
    send_item(make_item(OP_ERASE,      31'h6,   '0),      0);  // absent
    send_item(make_item(OP_AFTER,      '0,      ID_MAX),  0);  // now last entry
    send_item(make_item(OP_LAST,       ID_EVEN, ID_ODD),  0);
    send_item(make_item(OP_TAKE_FRONT, '0,      '0),      0);
    send_item(make_item(OP_TAKE_BACK,  '0,      '0),      0);
    send_item(make_item(OP_BEFORE,     '0,      ID_EVEN), 0);  // reference found: neighbor is ID zero
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(88, 32);   // sender idles about a third of the time
    run_random(88, 87);   // sender mostly idle
    run_random(80, 0);    // back to back

    start <= 1'b0;
    while (list_sb.outstanding() != 0) @(posedge clk);
    repeat (16) @(posedge clk);  // catch any stray strobe

    if (list_sb.fails == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (even 280 items, each on a full
  // list, plus idling, stays near 3 ms).
  initial begin
    #50_000_000ns;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
